// ===== rtl/lpfd_pkg.sv =====
// Shared types and constants of the length-prefixed frame deframer.
`timescale 1ns / 1ps
package lpfd_pkg;

    localparam logic [7:0] HDR_A = 8'h11;
    localparam logic [7:0] HDR_B = 8'h22;
    localparam logic [7:0] TL_A  = 8'h33;
    localparam logic [7:0] TL_B  = 8'h44;

    localparam int CKSUM_BYTES = 2;
    localparam int SKIP_W      = $clog2(CKSUM_BYTES + 1);

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int KIND_W  = 2;
    localparam int TDATA_W = ((BYTE_W + LEN_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD_END = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_END  = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT_A,
        PH_HUNT_B,
        PH_CKSUM,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_TAIL_A,
        PH_TAIL_B
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  frame_length;
    } result_t;

endpackage

// ===== rtl/lpfd_parser.sv =====
// Frame parser state machine: header hunt, checksum skip, length capture, payload and tail.
`timescale 1ns / 1ps
module lpfd_parser
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_fire,
    input  logic [7:0]              rx_byte,
    output lpfd_pkg::result_t       res
);
    import lpfd_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   declared_reg, declared_next;
    logic [LEN_W-1:0]   remaining_reg, remaining_next;
    logic [SKIP_W-1:0]  skip_reg, skip_next;
    phase_t             hunt_phase;
    logic [LEN_W-1:0]   len_full;

    // A byte that breaks the header or tail may itself open a new header.
    assign hunt_phase = (rx_byte == HDR_A) ? PH_HUNT_B : PH_HUNT_A;
    assign len_full   = {declared_reg[LEN_W-1:BYTE_W], rx_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT_A;
            declared_reg  <= '0;
            remaining_reg <= '0;
            skip_reg      <= '0;
        end
        else if (in_fire)
        begin
            phase_reg     <= phase_next;
            declared_reg  <= declared_next;
            remaining_reg <= remaining_next;
            skip_reg      <= skip_next;
        end
    end

    // Next state and counters.
    always_comb
    begin
        phase_next     = phase_reg;
        declared_next  = declared_reg;
        remaining_next = remaining_reg;
        skip_next      = skip_reg;
        unique case (phase_reg)
            PH_HUNT_A:
            begin
                phase_next = hunt_phase;
            end
            PH_HUNT_B:
            begin
                if (rx_byte == HDR_B)
                begin
                    phase_next = PH_CKSUM;
                    skip_next  = SKIP_W'(CKSUM_BYTES);
                end
                else
                begin
                    phase_next = hunt_phase;
                end
            end
            PH_CKSUM:
            begin
                if (skip_reg > SKIP_W'(1))
                begin
                    skip_next = skip_reg - SKIP_W'(1);
                end
                else
                begin
                    skip_next  = '0;
                    phase_next = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                declared_next = {rx_byte, {BYTE_W{1'b0}}};
                phase_next    = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                declared_next  = len_full;
                remaining_next = len_full;
                phase_next     = (len_full == '0) ? PH_TAIL_A : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                remaining_next = remaining_reg - LEN_W'(1);
                if (remaining_reg == LEN_W'(1))
                begin
                    phase_next = PH_TAIL_A;
                end
            end
            PH_TAIL_A:
            begin
                phase_next = (rx_byte == TL_A) ? PH_TAIL_B : hunt_phase;
            end
            PH_TAIL_B:
            begin
                phase_next = (rx_byte == TL_B) ? PH_HUNT_A : hunt_phase;
            end
            default:
            begin
                phase_next = hunt_phase;
            end
        endcase
    end

    // Result for the byte on the input.
    always_comb
    begin
        res              = '0;
        res.frame_length = declared_reg;
        unique case (phase_reg)
            PH_PAYLOAD:
            begin
                res.valid = 1'b1;
                res.kind  = KIND_PAYLOAD;
                res.data  = rx_byte;
            end
            PH_TAIL_A:
            begin
                if (rx_byte != TL_A)
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_BAD_END;
                end
            end
            PH_TAIL_B:
            begin
                res.valid = 1'b1;
                res.kind  = (rx_byte == TL_B) ? KIND_GOOD_END : KIND_BAD_END;
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/length_prefixed_frame_deframer.sv =====
// A result is registered and appears on the master side in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the slave side stalls only while a result is held
// in the output register and the master side is not ready.
// Reset: rst_n clears the parser to header hunt, the length and count to zero,
// and empties the output register.
`timescale 1ns / 1ps
module length_prefixed_frame_deframer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lpfd_pkg::TDATA_W-1:0]  m_tdata,  // [7:0] out_byte, [23:8] frame_length
    output logic [lpfd_pkg::KIND_W-1:0]   m_tuser   // [1:0] kind
);
    import lpfd_pkg::*;

    logic               in_fire;
    result_t            res;
    logic               out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [LEN_W-1:0]   out_len_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    lpfd_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .rx_byte (s_tdata),
        .res     (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = res.valid;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res.valid)
        begin
            out_kind_reg <= res.kind;
            out_byte_reg <= res.data;
            out_len_reg  <= res.frame_length;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = TDATA_W'({out_len_reg, out_byte_reg});

endmodule

// ===== rtl/lpfd_checker.sv =====
// Port-level assertions for the deframer and the bind that attaches them.
`timescale 1ns / 1ps
module lpfd_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [lpfd_pkg::TDATA_W-1:0]  m_tdata,
    input  logic [lpfd_pkg::KIND_W-1:0]   m_tuser
);
    import lpfd_pkg::*;

    // A held result keeps its contents until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A full output register that is not being drained must stall the input.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output register blocked");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == KIND_PAYLOAD) || (m_tuser == KIND_GOOD_END)
                     || (m_tuser == KIND_BAD_END))
        else $error("illegal result kind");

    a_end_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_PAYLOAD) |-> (m_tdata[7:0] == 8'h00))
        else $error("end-of-frame request carries a nonzero byte");

    // A request is never produced without an accepted byte in the cycle before.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("request produced without an accepted byte");

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
